// ----- design/ecu_pkg.sv -----
// Package for the 8-bit CPU execute unit.
// Holds operation codes, flag positions, reset values and the shared structs.
// No dependencies.
package ecu_pkg;

    // Operation codes carried in the kind field
    localparam logic [5:0] K_ADC   = 6'd0;
    localparam logic [5:0] K_SBC   = 6'd1;
    localparam logic [5:0] K_AND   = 6'd2;
    localparam logic [5:0] K_ORA   = 6'd3;
    localparam logic [5:0] K_EOR   = 6'd4;
    localparam logic [5:0] K_BIT   = 6'd5;
    localparam logic [5:0] K_CMP   = 6'd6;
    localparam logic [5:0] K_CPX   = 6'd7;
    localparam logic [5:0] K_CPY   = 6'd8;
    localparam logic [5:0] K_LDA   = 6'd9;
    localparam logic [5:0] K_LDX   = 6'd10;
    localparam logic [5:0] K_LDY   = 6'd11;
    localparam logic [5:0] K_STA   = 6'd12;
    localparam logic [5:0] K_STX   = 6'd13;
    localparam logic [5:0] K_STY   = 6'd14;
    localparam logic [5:0] K_ASL_A = 6'd15;
    localparam logic [5:0] K_ASL_M = 6'd16;
    localparam logic [5:0] K_LSR_A = 6'd17;
    localparam logic [5:0] K_LSR_M = 6'd18;
    localparam logic [5:0] K_ROL_A = 6'd19;
    localparam logic [5:0] K_ROL_M = 6'd20;
    localparam logic [5:0] K_ROR_A = 6'd21;
    localparam logic [5:0] K_ROR_M = 6'd22;
    localparam logic [5:0] K_INC   = 6'd23;
    localparam logic [5:0] K_DEC   = 6'd24;
    localparam logic [5:0] K_INX   = 6'd25;
    localparam logic [5:0] K_INY   = 6'd26;
    localparam logic [5:0] K_DEX   = 6'd27;
    localparam logic [5:0] K_DEY   = 6'd28;
    localparam logic [5:0] K_TAX   = 6'd29;
    localparam logic [5:0] K_TAY   = 6'd30;
    localparam logic [5:0] K_TSX   = 6'd31;
    localparam logic [5:0] K_TXA   = 6'd32;
    localparam logic [5:0] K_TXS   = 6'd33;
    localparam logic [5:0] K_TYA   = 6'd34;
    localparam logic [5:0] K_CLC   = 6'd35;
    localparam logic [5:0] K_CLD   = 6'd36;
    localparam logic [5:0] K_CLI   = 6'd37;
    localparam logic [5:0] K_CLV   = 6'd38;
    localparam logic [5:0] K_SEC   = 6'd39;
    localparam logic [5:0] K_SED   = 6'd40;
    localparam logic [5:0] K_SEI   = 6'd41;
    localparam logic [5:0] K_BCC   = 6'd42;
    localparam logic [5:0] K_BCS   = 6'd43;
    localparam logic [5:0] K_BEQ   = 6'd44;
    localparam logic [5:0] K_BMI   = 6'd45;
    localparam logic [5:0] K_BNE   = 6'd46;
    localparam logic [5:0] K_BPL   = 6'd47;
    localparam logic [5:0] K_BVC   = 6'd48;
    localparam logic [5:0] K_BVS   = 6'd49;
    localparam logic [5:0] K_PHA   = 6'd50;
    localparam logic [5:0] K_PHP   = 6'd51;
    localparam logic [5:0] K_PLA   = 6'd52;
    localparam logic [5:0] K_PLP   = 6'd53;
    localparam logic [5:0] K_NOP   = 6'd54;
    localparam logic [5:0] K_JMP   = 6'd55;

    // Status bit positions
    localparam int unsigned F_C = 0;
    localparam int unsigned F_Z = 1;
    localparam int unsigned F_I = 2;
    localparam int unsigned F_D = 3;
    localparam int unsigned F_B = 4;
    localparam int unsigned F_U = 5;
    localparam int unsigned F_V = 6;
    localparam int unsigned F_N = 7;

    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] SP_RESET   = 8'hFD;
    localparam logic [7:0] P_RESET    = 8'h20;

    // One decoded instruction
    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  operand_byte;
        logic [15:0] effective_address;
        logic [15:0] next_pc;
    } item_t;

    // Programmer-visible registers
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } regs_t;

    // Write and branch side of a result
    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        branch_taken;
        logic [15:0] new_pc;
        logic        page_crossed;
    } effect_t;

endpackage

// ----- design/ecu_in_stage.sv -----
// Input register of the execute unit: holds one item for the execute logic.
// Depends on ecu_pkg for item_t.
module ecu_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ecu_pkg::item_t item_in,
    input  logic          advance,
    output logic          held_valid,
    output ecu_pkg::item_t held_item
);
    import ecu_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// ----- design/ecu_exec.sv -----
// Combinational execute logic: one instruction against the current registers.
// Depends on ecu_pkg for codes, flag positions and structs.
module ecu_exec (
    input  ecu_pkg::item_t   item,
    input  ecu_pkg::regs_t   cur,
    output ecu_pkg::regs_t   nxt,
    output ecu_pkg::effect_t eff
);
    import ecu_pkg::*;

    // Update N and Z from a result byte
    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q      = p;
        q[F_Z] = (v == 8'h00);
        q[F_N] = v[7];
        return q;
    endfunction

    logic [7:0] m;
    logic [7:0] m_eff;
    logic [8:0] sum;
    logic [7:0] sum_r;
    logic       sum_v;
    logic [7:0] cmp_reg;
    logic [8:0] diff;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_c;
    logic [7:0] m_inc;
    logic [7:0] m_dec;
    logic [15:0] target;
    logic        cond;
    logic        is_branch;

    assign m = item.operand_byte;

    // Adder shared by ADC and SBC (SBC adds the inverted operand)
    assign m_eff = (item.kind == K_SBC) ? ~m : m;
    assign sum   = {1'b0, cur.acc} + {1'b0, m_eff} + {8'h00, cur.p[F_C]};
    assign sum_r = sum[7:0];
    assign sum_v = ~(cur.acc[7] ^ m_eff[7]) & (cur.acc[7] ^ sum_r[7]);

    // Compare: register minus operand, carry is not-borrow
    always_comb
    begin
        case (item.kind)
            K_CPX:   cmp_reg = cur.x;
            K_CPY:   cmp_reg = cur.y;
            default: cmp_reg = cur.acc;
        endcase
    end
    assign diff = {1'b0, cmp_reg} - {1'b0, m};

    // Shifter: accumulator forms use A, memory forms use the operand
    always_comb
    begin
        case (item.kind)
            K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A: sh_src = cur.acc;
            default:                            sh_src = m;
        endcase
        case (item.kind)
            K_ASL_A, K_ASL_M:
            begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            K_LSR_A, K_LSR_M:
            begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            K_ROL_A, K_ROL_M:
            begin
                sh_res = {sh_src[6:0], cur.p[F_C]};
                sh_c   = sh_src[7];
            end
            default:
            begin
                sh_res = {cur.p[F_C], sh_src[7:1]};
                sh_c   = sh_src[0];
            end
        endcase
    end

    assign m_inc  = m + 8'd1;
    assign m_dec  = m - 8'd1;
    assign target = item.next_pc + {{8{m[7]}}, m};

    // Branch conditions
    always_comb
    begin
        is_branch = 1'b1;
        case (item.kind)
            K_BCC:   cond = !cur.p[F_C];
            K_BCS:   cond = cur.p[F_C];
            K_BEQ:   cond = cur.p[F_Z];
            K_BMI:   cond = cur.p[F_N];
            K_BNE:   cond = !cur.p[F_Z];
            K_BPL:   cond = !cur.p[F_N];
            K_BVC:   cond = !cur.p[F_V];
            K_BVS:   cond = cur.p[F_V];
            default:
            begin
                cond      = 1'b0;
                is_branch = 1'b0;
            end
        endcase
    end

    // Main operation select
    always_comb
    begin
        nxt = cur;
        eff = '0;
        eff.new_pc = item.next_pc;
        case (item.kind)
            K_ADC, K_SBC:
            begin
                nxt.acc    = sum_r;
                nxt.p      = set_nz(cur.p, sum_r);
                nxt.p[F_C] = sum[8];
                nxt.p[F_V] = sum_v;
            end
            K_AND:
            begin
                nxt.acc = cur.acc & m;
                nxt.p   = set_nz(cur.p, cur.acc & m);
            end
            K_ORA:
            begin
                nxt.acc = cur.acc | m;
                nxt.p   = set_nz(cur.p, cur.acc | m);
            end
            K_EOR:
            begin
                nxt.acc = cur.acc ^ m;
                nxt.p   = set_nz(cur.p, cur.acc ^ m);
            end
            K_BIT:
            begin
                nxt.p[F_Z] = ((cur.acc & m) == 8'h00);
                nxt.p[F_N] = m[7];
                nxt.p[F_V] = m[6];
            end
            K_CMP, K_CPX, K_CPY:
            begin
                nxt.p      = set_nz(cur.p, diff[7:0]);
                nxt.p[F_C] = !diff[8];
            end
            K_LDA:
            begin
                nxt.acc = m;
                nxt.p   = set_nz(cur.p, m);
            end
            K_LDX:
            begin
                nxt.x = m;
                nxt.p = set_nz(cur.p, m);
            end
            K_LDY:
            begin
                nxt.y = m;
                nxt.p = set_nz(cur.p, m);
            end
            K_STA, K_STX, K_STY:
            begin
                eff.write_enable  = 1'b1;
                eff.write_address = item.effective_address;
                eff.write_data    = (item.kind == K_STA) ? cur.acc :
                                    (item.kind == K_STX) ? cur.x : cur.y;
            end
            K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A:
            begin
                nxt.acc    = sh_res;
                nxt.p      = set_nz(cur.p, sh_res);
                nxt.p[F_C] = sh_c;
            end
            K_ASL_M, K_LSR_M, K_ROL_M, K_ROR_M:
            begin
                eff.write_enable  = 1'b1;
                eff.write_address = item.effective_address;
                eff.write_data    = sh_res;
                nxt.p             = set_nz(cur.p, sh_res);
                nxt.p[F_C]        = sh_c;
            end
            K_INC:
            begin
                eff.write_enable  = 1'b1;
                eff.write_address = item.effective_address;
                eff.write_data    = m_inc;
                nxt.p             = set_nz(cur.p, m_inc);
            end
            K_DEC:
            begin
                eff.write_enable  = 1'b1;
                eff.write_address = item.effective_address;
                eff.write_data    = m_dec;
                nxt.p             = set_nz(cur.p, m_dec);
            end
            K_INX:
            begin
                nxt.x = cur.x + 8'd1;
                nxt.p = set_nz(cur.p, cur.x + 8'd1);
            end
            K_INY:
            begin
                nxt.y = cur.y + 8'd1;
                nxt.p = set_nz(cur.p, cur.y + 8'd1);
            end
            K_DEX:
            begin
                nxt.x = cur.x - 8'd1;
                nxt.p = set_nz(cur.p, cur.x - 8'd1);
            end
            K_DEY:
            begin
                nxt.y = cur.y - 8'd1;
                nxt.p = set_nz(cur.p, cur.y - 8'd1);
            end
            K_TAX:
            begin
                nxt.x = cur.acc;
                nxt.p = set_nz(cur.p, cur.acc);
            end
            K_TAY:
            begin
                nxt.y = cur.acc;
                nxt.p = set_nz(cur.p, cur.acc);
            end
            K_TSX:
            begin
                nxt.x = cur.sp;
                nxt.p = set_nz(cur.p, cur.sp);
            end
            K_TXA:
            begin
                nxt.acc = cur.x;
                nxt.p   = set_nz(cur.p, cur.x);
            end
            K_TXS:
            begin
                nxt.sp = cur.x;
            end
            K_TYA:
            begin
                nxt.acc = cur.y;
                nxt.p   = set_nz(cur.p, cur.y);
            end
            K_CLC: nxt.p[F_C] = 1'b0;
            K_CLD: nxt.p[F_D] = 1'b0;
            K_CLI: nxt.p[F_I] = 1'b0;
            K_CLV: nxt.p[F_V] = 1'b0;
            K_SEC: nxt.p[F_C] = 1'b1;
            K_SED: nxt.p[F_D] = 1'b1;
            K_SEI: nxt.p[F_I] = 1'b1;
            K_PHA, K_PHP:
            begin
                eff.write_enable  = 1'b1;
                eff.write_address = {STACK_PAGE, cur.sp};
                eff.write_data    = (item.kind == K_PHA) ? cur.acc :
                                    (cur.p | 8'h30);
                nxt.sp            = cur.sp - 8'd1;
            end
            K_PLA:
            begin
                nxt.sp  = cur.sp + 8'd1;
                nxt.acc = m;
                nxt.p   = set_nz(cur.p, m);
            end
            K_PLP:
            begin
                nxt.sp     = cur.sp + 8'd1;
                nxt.p      = m;
                nxt.p[F_B] = 1'b0;
                nxt.p[F_U] = 1'b1;
            end
            K_JMP:
            begin
                eff.branch_taken = 1'b1;
                eff.new_pc       = item.effective_address;
            end
            default:
            begin
                // NOP and unused codes leave everything as is
            end
        endcase

        // Taken relative branch
        if (is_branch && cond)
        begin
            eff.branch_taken = 1'b1;
            eff.new_pc       = target;
            eff.page_crossed = (target[15:8] != item.next_pc[15:8]);
        end
    end

endmodule

// ----- design/eight_bit_cpu_execute_unit.sv -----
// Top level of the 8-bit CPU execute unit: register file, result register.
// Depends on ecu_pkg, ecu_in_stage and ecu_exec.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per
//   item: kind, operand_byte, effective_address, next_pc. Output channel
//   (out_valid/out_ready) carries one result item per instruction: the
//   memory/stack write, the branch outcome and A, X, Y, SP, P afterwards.
//   An accepted item waits in the input register, executes against
//   A/X/Y/SP/P there and is shown on the outputs from the result
//   register, which it enters when it advances.
//   Throughput: one item per cycle while the receiver does not stall; the
//   A/X/Y/SP/P feedback through the execute logic is a combinational path,
//   so dependent instructions follow back to back.
//   When the receiver stalls, the result register holds; one more item
//   waits in the input register, then in_ready drops.
//   Reset: A, X, Y = 0, SP = 0xFD, P = 0x20; both stages empty.
module eight_bit_cpu_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  kind,
    input  logic [7:0]  operand_byte,
    input  logic [15:0] effective_address,
    input  logic [15:0] next_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_enable,
    output logic [15:0] write_address,
    output logic [7:0]  write_data,
    output logic        branch_taken,
    output logic [15:0] new_pc,
    output logic        page_crossed,
    output logic [7:0]  acc_out,
    output logic [7:0]  x_out,
    output logic [7:0]  y_out,
    output logic [7:0]  sp_out,
    output logic [7:0]  status_out
);
    import ecu_pkg::*;

    item_t   item_in;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    regs_t   state_reg;
    regs_t   state_next;
    effect_t eff_next;
    effect_t eff_reg;
    regs_t   shown_reg;
    logic    out_valid_reg;

    assign item_in = '{kind: kind, operand_byte: operand_byte,
                       effective_address: effective_address, next_pc: next_pc};

    // Held item executes when the result register is free or being drained
    assign advance = held_valid && (!out_valid_reg || out_ready);

    ecu_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ecu_exec u_exec (
        .item (held_item),
        .cur  (state_reg),
        .nxt  (state_next),
        .eff  (eff_next)
    );

    // Architectural registers and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{acc: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: P_RESET};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            eff_reg   <= eff_next;
            shown_reg <= state_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = eff_reg.write_enable;
    assign write_address = eff_reg.write_address;
    assign write_data    = eff_reg.write_data;
    assign branch_taken  = eff_reg.branch_taken;
    assign new_pc        = eff_reg.new_pc;
    assign page_crossed  = eff_reg.page_crossed;
    assign acc_out       = shown_reg.acc;
    assign x_out         = shown_reg.x;
    assign y_out         = shown_reg.y;
    assign sp_out        = shown_reg.sp;
    assign status_out    = shown_reg.p;

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for eight_bit_cpu_execute_unit: directed instruction table, then random items.
// Checked against a register-level predictor of the execute stage, or a typed row's result.
// Depends on ecu_pkg and the eight_bit_cpu_execute_unit RTL.
`timescale 1ns / 1ps

module testbench;
    import ecu_pkg::*;

    localparam int RANDOM_ITEMS   = 1850;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [5:0] KIND_UNUSED_TOP = 6'd63;

    typedef enum logic [1:0] {SH_ASL, SH_LSR, SH_ROL, SH_ROR} shift_e;

    // Full result of one retired instruction
    typedef struct packed {
        effect_t eff;
        regs_t   regs;
    } outcome_t;

    // One row of the directed table; typed rows carry their result literally
    typedef struct packed {
        item_t    ins;
        logic     typed;
        outcome_t want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [5:0]  kind;
    logic [7:0]  operand_byte;
    logic [15:0] effective_address;
    logic [15:0] next_pc;
    logic        out_valid;
    logic        out_ready;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        branch_taken;
    logic [15:0] new_pc;
    logic        page_crossed;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;

    // Predicted architectural state
    logic [7:0] cpu_a;
    logic [7:0] cpu_x;
    logic [7:0] cpu_y;
    logic [7:0] cpu_sp;
    logic [7:0] cpu_p;

    outcome_t retire_q[$];
    int       items_sent;
    int       retired_count;
    int       error_count;

    // Directed instructions: reset values, carry and overflow extremes,
    // transfers, stack wrap, branches across pages, unused code.
    localparam int PLAN_LEN = 27;
    step_t plan [PLAN_LEN] = '{
        '{{K_NOP, 8'h00, 16'h0000, 16'h0000}, 1'b1,
          {1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 1'b0,
           8'h00, 8'h00, 8'h00, 8'hFD, 8'h20}},
        '{{K_PHP, 8'h00, 16'h0000, 16'h1234}, 1'b1,
          {1'b1, 16'h01FD, 8'h30, 1'b0, 16'h1234, 1'b0,
           8'h00, 8'h00, 8'h00, 8'hFC, 8'h20}},
        '{{K_LDA, 8'hFF, 16'h0000, 16'hFFFF}, 1'b1,
          {1'b0, 16'h0000, 8'h00, 1'b0, 16'hFFFF, 1'b0,
           8'hFF, 8'h00, 8'h00, 8'hFC, 8'hA0}},
        '{{K_ADC, 8'h01, 16'h0000, 16'h0000}, 1'b1,
          {1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 1'b0,
           8'h00, 8'h00, 8'h00, 8'hFC, 8'h23}},
        '{{K_SBC,   8'hFF, 16'h0000, 16'h0002}, 1'b0, '0},
        '{{K_LDA,   8'h7F, 16'h0000, 16'h0004}, 1'b0, '0},
        '{{K_ADC,   8'h01, 16'h0000, 16'h0006}, 1'b0, '0},
        '{{K_SBC,   8'h01, 16'h0000, 16'h0008}, 1'b0, '0},
        '{{K_CMP,   8'hFF, 16'h0000, 16'h000A}, 1'b0, '0},
        '{{K_LDX,   8'h80, 16'h0000, 16'h000C}, 1'b0, '0},
        '{{K_TXA,   8'h00, 16'h0000, 16'h000D}, 1'b0, '0},
        '{{K_TYA,   8'h00, 16'h0000, 16'h000E}, 1'b0, '0},
        '{{K_PLP,   8'hFF, 16'h0000, 16'h000F}, 1'b0, '0},
        '{{K_BVS,   8'h80, 16'h0000, 16'h0100}, 1'b0, '0},
        '{{K_BMI,   8'h7F, 16'h0000, 16'h00F0}, 1'b0, '0},
        '{{K_BCC,   8'h10, 16'h0000, 16'h0200}, 1'b0, '0},
        '{{K_ADC,   8'h00, 16'h0000, 16'h0202}, 1'b0, '0},
        '{{K_LDX,   8'h00, 16'h0000, 16'h0204}, 1'b0, '0},
        '{{K_TXS,   8'h00, 16'h0000, 16'h0205}, 1'b0, '0},
        '{{K_PHA,   8'h00, 16'hFFFF, 16'h0206}, 1'b0, '0},
        '{{K_PLA,   8'h80, 16'h0000, 16'h0207}, 1'b0, '0},
        '{{K_ROR_M, 8'h01, 16'hFFFF, 16'h0208}, 1'b0, '0},
        '{{K_INC,   8'hFF, 16'h8000, 16'h020B}, 1'b0, '0},
        '{{K_DEC,   8'h00, 16'h00FF, 16'h020E}, 1'b0, '0},
        '{{K_ASL_A, 8'h00, 16'h0000, 16'h0211}, 1'b0, '0},
        '{{K_JMP,   8'h00, 16'hFFFF, 16'h4000}, 1'b0, '0},
        '{{KIND_UNUSED_TOP, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
    };

    eight_bit_cpu_execute_unit dut (.*);

    // Predictor ------------------------------------------------------------

    // Update N and Z from a result byte
    function automatic logic [7:0] flag_nz(input logic [7:0] v);
        cpu_p[F_Z] = (v == 8'h00);
        cpu_p[F_N] = v[7];
        return v;
    endfunction

    // Binary A + m + C; SBC passes the inverted operand
    function automatic logic [7:0] add_with_carry(input logic [7:0] m);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[F_C]};
        r = sum[7:0];
        cpu_p[F_C] = sum[8];
        cpu_p[F_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ r[7]);
        return flag_nz(r);
    endfunction

    function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        cpu_p[F_C] = (r >= m);
        void'(flag_nz(diff));
    endfunction

    function automatic logic [7:0] shift_rot(input shift_e op, input logic [7:0] v);
        logic [7:0] r;
        logic       cin;
        cin = cpu_p[F_C];
        case (op)
            SH_ASL:  begin r = {v[6:0], 1'b0}; cpu_p[F_C] = v[7]; end
            SH_LSR:  begin r = {1'b0, v[7:1]}; cpu_p[F_C] = v[0]; end
            SH_ROL:  begin r = {v[6:0], cin};  cpu_p[F_C] = v[7]; end
            default: begin r = {cin, v[7:1]};  cpu_p[F_C] = v[0]; end
        endcase
        return flag_nz(r);
    endfunction

    // Execute one instruction against the predicted state
    function automatic outcome_t execute_instruction(input item_t ins);
        outcome_t    o;
        logic [7:0]  m;
        logic        mem_wr;
        logic [7:0]  mem_data;
        logic        is_branch;
        logic        cond;
        logic [15:0] target;
        o = '0;
        m = ins.operand_byte;
        mem_wr = 1'b0;
        mem_data = 8'h00;
        is_branch = 1'b0;
        cond = 1'b0;
        o.eff.new_pc = ins.next_pc;
        case (ins.kind)
            K_ADC:   cpu_a = add_with_carry(m);
            K_SBC:   cpu_a = add_with_carry(~m);
            K_AND:   cpu_a = flag_nz(cpu_a & m);
            K_ORA:   cpu_a = flag_nz(cpu_a | m);
            K_EOR:   cpu_a = flag_nz(cpu_a ^ m);
            K_BIT:
            begin
                cpu_p[F_Z] = ((cpu_a & m) == 8'h00);
                cpu_p[F_N] = m[7];
                cpu_p[F_V] = m[6];
            end
            K_CMP:   compare_reg(cpu_a, m);
            K_CPX:   compare_reg(cpu_x, m);
            K_CPY:   compare_reg(cpu_y, m);
            K_LDA:   cpu_a = flag_nz(m);
            K_LDX:   cpu_x = flag_nz(m);
            K_LDY:   cpu_y = flag_nz(m);
            K_STA:   begin mem_wr = 1'b1; mem_data = cpu_a; end
            K_STX:   begin mem_wr = 1'b1; mem_data = cpu_x; end
            K_STY:   begin mem_wr = 1'b1; mem_data = cpu_y; end
            K_ASL_A: cpu_a = shift_rot(SH_ASL, cpu_a);
            K_LSR_A: cpu_a = shift_rot(SH_LSR, cpu_a);
            K_ROL_A: cpu_a = shift_rot(SH_ROL, cpu_a);
            K_ROR_A: cpu_a = shift_rot(SH_ROR, cpu_a);
            K_ASL_M: begin mem_wr = 1'b1; mem_data = shift_rot(SH_ASL, m); end
            K_LSR_M: begin mem_wr = 1'b1; mem_data = shift_rot(SH_LSR, m); end
            K_ROL_M: begin mem_wr = 1'b1; mem_data = shift_rot(SH_ROL, m); end
            K_ROR_M: begin mem_wr = 1'b1; mem_data = shift_rot(SH_ROR, m); end
            K_INC:   begin mem_wr = 1'b1; mem_data = flag_nz(m + 8'd1); end
            K_DEC:   begin mem_wr = 1'b1; mem_data = flag_nz(m - 8'd1); end
            K_INX:   cpu_x = flag_nz(cpu_x + 8'd1);
            K_INY:   cpu_y = flag_nz(cpu_y + 8'd1);
            K_DEX:   cpu_x = flag_nz(cpu_x - 8'd1);
            K_DEY:   cpu_y = flag_nz(cpu_y - 8'd1);
            K_TAX:   cpu_x = flag_nz(cpu_a);
            K_TAY:   cpu_y = flag_nz(cpu_a);
            K_TSX:   cpu_x = flag_nz(cpu_sp);
            K_TXA:   cpu_a = flag_nz(cpu_x);
            K_TXS:   cpu_sp = cpu_x;
            K_TYA:   cpu_a = flag_nz(cpu_y);
            K_CLC:   cpu_p[F_C] = 1'b0;
            K_CLD:   cpu_p[F_D] = 1'b0;
            K_CLI:   cpu_p[F_I] = 1'b0;
            K_CLV:   cpu_p[F_V] = 1'b0;
            K_SEC:   cpu_p[F_C] = 1'b1;
            K_SED:   cpu_p[F_D] = 1'b1;
            K_SEI:   cpu_p[F_I] = 1'b1;
            K_BCC:   begin is_branch = 1'b1; cond = !cpu_p[F_C]; end
            K_BCS:   begin is_branch = 1'b1; cond = cpu_p[F_C]; end
            K_BEQ:   begin is_branch = 1'b1; cond = cpu_p[F_Z]; end
            K_BMI:   begin is_branch = 1'b1; cond = cpu_p[F_N]; end
            K_BNE:   begin is_branch = 1'b1; cond = !cpu_p[F_Z]; end
            K_BPL:   begin is_branch = 1'b1; cond = !cpu_p[F_N]; end
            K_BVC:   begin is_branch = 1'b1; cond = !cpu_p[F_V]; end
            K_BVS:   begin is_branch = 1'b1; cond = cpu_p[F_V]; end
            K_PHA:
            begin
                o.eff.write_enable  = 1'b1;
                o.eff.write_address = {STACK_PAGE, cpu_sp};
                o.eff.write_data    = cpu_a;
                cpu_sp = cpu_sp - 8'd1;
            end
            K_PHP:
            begin
                o.eff.write_enable  = 1'b1;
                o.eff.write_address = {STACK_PAGE, cpu_sp};
                o.eff.write_data    = cpu_p;
                o.eff.write_data[F_B] = 1'b1;
                o.eff.write_data[F_U] = 1'b1;
                cpu_sp = cpu_sp - 8'd1;
            end
            K_PLA:
            begin
                cpu_sp = cpu_sp + 8'd1;
                cpu_a = flag_nz(m);
            end
            K_PLP:
            begin
                cpu_sp = cpu_sp + 8'd1;
                cpu_p = m;
                cpu_p[F_B] = 1'b0;
                cpu_p[F_U] = 1'b1;
            end
            K_JMP:
            begin
                o.eff.branch_taken = 1'b1;
                o.eff.new_pc = ins.effective_address;
            end
            default: ;  // NOP and unused codes
        endcase

        if (mem_wr) begin
            o.eff.write_enable  = 1'b1;
            o.eff.write_address = ins.effective_address;
            o.eff.write_data    = mem_data;
        end

        // Relative branch: sign-extended offset, page check on the high byte
        if (is_branch && cond) begin
            target = ins.next_pc + {{8{m[7]}}, m};
            o.eff.branch_taken = 1'b1;
            o.eff.new_pc = target;
            o.eff.page_crossed = (target[15:8] != ins.next_pc[15:8]);
        end

        o.regs.acc = cpu_a;
        o.regs.x   = cpu_x;
        o.regs.y   = cpu_y;
        o.regs.sp  = cpu_sp;
        o.regs.p   = cpu_p;
        return o;
    endfunction

    // Stimulus helpers -------------------------------------------------------

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(99) < 20)
            return corners[$urandom_range(4)];
        return 8'($urandom);
    endfunction

    function automatic item_t random_instruction();
        item_t ins;
        if ($urandom_range(99) < 4)
            ins.kind = 6'($urandom_range(56, 63));
        else
            ins.kind = 6'($urandom_range(0, 55));
        ins.operand_byte = pick_byte();
        ins.effective_address = ($urandom_range(9) == 0) ? {2{pick_byte()}}
                                                          : 16'($urandom);
        // Land many program counters near a page edge
        if ($urandom_range(3) == 0)
            ins.next_pc = {8'($urandom),
                           ($urandom_range(1) == 1) ? 8'($urandom_range(8'hF0, 8'hFF))
                                                     : 8'($urandom_range(8'h00, 8'h0F))};
        else
            ins.next_pc = 16'($urandom);
        return ins;
    endfunction

    // Offer one item with random gaps (none for items 300 to 649); predict on acceptance
    task automatic offer(input item_t ins, input logic typed, input outcome_t want);
        outcome_t predicted;
        while (!(items_sent >= 300 && items_sent < 650) && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        kind              <= ins.kind;
        operand_byte      <= ins.operand_byte;
        effective_address <= ins.effective_address;
        next_pc           <= ins.next_pc;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = execute_instruction(ins);
        retire_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Reset, directed table, random items, drain and verdict
    initial begin
        cpu_a  = 8'h00;
        cpu_x  = 8'h00;
        cpu_y  = 8'h00;
        cpu_sp = SP_RESET;
        cpu_p  = P_RESET;
        items_sent = 0;
        error_count = 0;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        kind              <= K_NOP;
        operand_byte      <= 8'h00;
        effective_address <= 16'h0000;
        next_pc           <= 16'h0000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
            offer(plan[i].ins, plan[i].typed, plan[i].want);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            offer(random_instruction(), 1'b0, '0);
        in_valid <= 1'b0;

        while (retire_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("eight_bit_cpu_execute_unit verification clean");
        else
            $display("eight_bit_cpu_execute_unit verification failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, one stretch with no stalls
    initial begin
        bit held_off;
        held_off = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && retired_count >= 800) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else if (retired_count >= 1200 && retired_count < 1500)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 30);
        end
    end

    // Result checker
    initial begin
        outcome_t want;
        retired_count = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (retire_q.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    error_count++;
                end
                else begin
                    want = retire_q.pop_front();
                    check_field("write_enable",  16'(want.eff.write_enable),
                                16'(write_enable));
                    check_field("write_address", want.eff.write_address, write_address);
                    check_field("write_data",    16'(want.eff.write_data),
                                16'(write_data));
                    check_field("branch_taken",  16'(want.eff.branch_taken),
                                16'(branch_taken));
                    check_field("new_pc",        want.eff.new_pc,        new_pc);
                    check_field("page_crossed",  16'(want.eff.page_crossed),
                                16'(page_crossed));
                    check_field("acc_out",       16'(want.regs.acc),     16'(acc_out));
                    check_field("x_out",         16'(want.regs.x),       16'(x_out));
                    check_field("y_out",         16'(want.regs.y),       16'(y_out));
                    check_field("sp_out",        16'(want.regs.sp),      16'(sp_out));
                    check_field("status_out",    16'(want.regs.p),       16'(status_out));
                end
                retired_count++;
            end
        end
    end

    // Watchdog: too many cycles with no item moving on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("eight_bit_cpu_execute_unit verification failed");
        $finish;
    end

endmodule
